FILE: hdl/median3x3_luma_vuya_core_assert.svh
// Assertion macros used by the median filter core.
`ifndef MEDIAN3X3_LUMA_VUYA_CORE_ASSERT_SVH
`define MEDIAN3X3_LUMA_VUYA_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MED3X3_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MED3X3_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/med3x3_pkg.sv
// Types and constants shared by the 3x3 luma median filter.
package med3x3_pkg;

    localparam int unsigned PIX_W        = 32;
    localparam int unsigned LUMA_W       = 8;
    localparam int unsigned LUMA_LSB     = 16;
    localparam logic [PIX_W-1:0] LUMA_MASK = 32'h00FF_0000;
    localparam int unsigned CFG_W        = 12;
    localparam int unsigned CFG_MAX      = 4095;
    localparam int unsigned KERNEL_SIDE  = 3;
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [LUMA_W-1:0] luma_t;

    typedef struct packed {
        luma_t top;
        luma_t mid;
        luma_t bot;
    } luma_col_t;

endpackage

FILE: hdl/med3x3_if.sv
// Stream and configuration channel interfaces of the median filter.
interface med3x3_pix_if
    import med3x3_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_word;
    logic             drain;

    modport source (output valid, pixel_word, drain, input ready);
    modport sink (input valid, pixel_word, drain, output ready);
endinterface

interface med3x3_out_if
    import med3x3_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_pixel;
    logic             frame_end;

    modport source (output valid, out_pixel, frame_end, input ready);
    modport sink (input valid, out_pixel, frame_end, output ready);
endinterface

interface med3x3_cfg_if
    import med3x3_pkg::*;
();
    logic             valid;
    logic             ready;
    cfg_reg_t         reg_index;
    logic [CFG_W-1:0] wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink (input valid, reg_index, wr_data, output ready);
endinterface

FILE: hdl/med3x3_median9.sv
// Median of a 3x3 luma window built from sorted columns.
module med3x3_median9
    import med3x3_pkg::*;
(
    input  luma_col_t left,
    input  luma_col_t centre,
    input  luma_col_t right,
    output luma_t     median
);

    function automatic luma_t min2(input luma_t a, input luma_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic luma_t max2(input luma_t a, input luma_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic luma_t med3(input luma_t a, input luma_t b, input luma_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    // Sorted so that top is the smallest and bot the largest value.
    function automatic luma_col_t sort3(input luma_col_t c);
        luma_col_t s;
        s.top = min2(min2(c.top, c.mid), c.bot);
        s.bot = max2(max2(c.top, c.mid), c.bot);
        s.mid = med3(c.top, c.mid, c.bot);
        return s;
    endfunction

    luma_col_t sl;
    luma_col_t sc;
    luma_col_t sr;
    luma_t     lo_max;
    luma_t     mid_med;
    luma_t     hi_min;

    always_comb
    begin
        sl      = sort3(left);
        sc      = sort3(centre);
        sr      = sort3(right);
        lo_max  = max2(max2(sl.top, sc.top), sr.top);
        mid_med = med3(sl.mid, sc.mid, sr.mid);
        hi_min  = min2(min2(sl.bot, sc.bot), sr.bot);
        median  = med3(lo_max, mid_med, hi_min);
    end

endmodule

FILE: hdl/median3x3_luma_vuya_core.sv
// Top level of the streaming 3x3 luma median filter for packed VUYA words.
//
//   channel   dir   word
//   pix_in    in    pixel_word[31:0], drain
//   pix_out   out   out_pixel[31:0], frame_end
//   cfg       in    reg_index (frame width, frame height), wr_data[11:0]
//
// One word per clock is sustained while the output is not stalled; a word passes
// through the line store read stage and then the output register, which holds the
// result for the word that completes it. Output trails input by one line plus one pixel, and
// frame_width + 1 drain words flush the end of a frame. The line stores need no
// clearing after reset. A stalled output holds the read stage, which holds input.
module median3x3_luma_vuya_core
    import med3x3_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = 2048,
    parameter int unsigned MAX_HEIGHT = 2048
)
(
    input  logic                clk,
    input  logic                rst_n,
    med3x3_pix_if.sink          pix_in,
    med3x3_out_if.source        pix_out,
    med3x3_cfg_if.sink          cfg
);

    localparam int unsigned WCAP  = (MAX_WIDTH > CFG_MAX) ? CFG_MAX : MAX_WIDTH;
    localparam int unsigned HCAP  = (MAX_HEIGHT > CFG_MAX) ? CFG_MAX : MAX_HEIGHT;
    localparam int unsigned AW    = $clog2(MAX_WIDTH);
    localparam int unsigned ROW_W = $clog2(HCAP + 2);

    typedef struct packed {
        logic             eor;
        logic             fend;
        logic             load;
        logic             col0;
        logic             top_up;
        logic             use_pix;
        logic             wr;
        logic [AW-1:0]    addr;
        logic [PIX_W-1:0] pix;
    } s1_ctrl_t;

    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic [AW-1:0]    col_reg;
    logic [AW-1:0]    col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    logic [CFG_W-1:0] w_eff;
    logic [CFG_W-1:0] h_eff;
    logic [AW-1:0]    w_last;
    logic [ROW_W-1:0] h_row;
    logic [ROW_W-1:0] h_plus1;
    logic             size_ok;
    logic             row_ge1;
    logic             row_ge2;
    logic             row_lt_h;
    logic             tail_end;
    logic             col_zero;
    logic             col_last;
    logic             cfg_fire;
    logic             in_fire;
    logic             act;

    logic             s1_valid_reg;
    logic             s1_valid_next;
    s1_ctrl_t         s1_reg;
    s1_ctrl_t         s1_next;
    logic             s1_emit;
    logic             s1_go;

    logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
    logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
    logic [PIX_W-1:0] upper_rdata_reg;
    logic [PIX_W-1:0] mid_rdata_reg;
    logic [PIX_W-1:0] top_word;
    logic             wr_en;

    luma_col_t        c1_reg;
    luma_col_t        c2_reg;
    logic [PIX_W-1:0] cw2_reg;
    luma_col_t        new_col;
    luma_col_t        right_col;
    luma_t            median;

    logic             out_valid_reg;
    logic [PIX_W-1:0] out_pixel_reg;
    logic             frame_end_reg;

    function automatic luma_t luma_of(input logic [PIX_W-1:0] w);
        return w[LUMA_LSB +: LUMA_W];
    endfunction

    // Configuration registers.
    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid & cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_fire)
        begin
            case (cfg.reg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg.wr_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg.wr_data;
                default:          frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    // Cursor decode.
    always_comb
    begin
        w_eff    = (frame_width_reg > CFG_W'(WCAP)) ? CFG_W'(WCAP) : frame_width_reg;
        h_eff    = (frame_height_reg > CFG_W'(HCAP)) ? CFG_W'(HCAP) : frame_height_reg;
        w_last   = AW'(w_eff - CFG_W'(1));
        h_row    = ROW_W'(h_eff);
        h_plus1  = h_row + ROW_W'(1);
        size_ok  = (w_eff >= CFG_W'(KERNEL_SIDE)) && (h_eff >= CFG_W'(KERNEL_SIDE));
        row_ge1  = (row_reg != '0);
        row_ge2  = (row_reg >= ROW_W'(2));
        row_lt_h = (row_reg < h_row);
        tail_end = (row_reg >= h_plus1);
        col_zero = (col_reg == '0);
        col_last = (col_reg == w_last);
    end

    assign in_fire      = pix_in.valid & pix_in.ready;
    assign act          = in_fire & size_ok & ~(row_lt_h & pix_in.drain);
    assign pix_in.ready = ~s1_valid_reg | s1_go;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_fire)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (act)
        begin
            if (tail_end)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_last)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Read stage control.
    always_comb
    begin
        s1_next.eor     = col_zero & row_ge2;
        s1_next.fend    = tail_end;
        s1_next.load    = row_ge1 & ~tail_end;
        s1_next.col0    = col_zero;
        s1_next.top_up  = row_ge2;
        s1_next.use_pix = row_lt_h;
        s1_next.wr      = row_lt_h;
        s1_next.addr    = col_reg;
        s1_next.pix     = pix_in.pixel_word;
    end

    assign s1_emit = s1_reg.eor | (s1_reg.load & ~s1_reg.col0);
    assign s1_go   = s1_valid_reg & (~s1_emit | ~out_valid_reg | pix_out.ready);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (!s1_valid_reg || s1_go)
        begin
            s1_valid_next = act;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (act)
        begin
            s1_reg <= s1_next;
        end
    end

    // Line stores. The entry written by the read stage is always a different
    // column from the one read in the same cycle, as width is at least three.
    assign wr_en = s1_go & s1_reg.wr;

    always_ff @(posedge clk)
    begin
        if (act)
        begin
            upper_rdata_reg <= upper_mem[col_reg];
        end
        if (wr_en)
        begin
            upper_mem[s1_reg.addr] <= mid_rdata_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (act)
        begin
            mid_rdata_reg <= middle_mem[col_reg];
        end
        if (wr_en)
        begin
            middle_mem[s1_reg.addr] <= s1_reg.pix;
        end
    end

    // Window update and median.
    always_comb
    begin
        top_word    = s1_reg.top_up ? upper_rdata_reg : mid_rdata_reg;
        new_col.top = luma_of(top_word);
        new_col.mid = luma_of(mid_rdata_reg);
        new_col.bot = s1_reg.use_pix ? luma_of(s1_reg.pix) : luma_of(mid_rdata_reg);
        right_col   = s1_reg.eor ? c2_reg : new_col;
    end

    med3x3_median9 u_median
    (
        .left   (c1_reg),
        .centre (c2_reg),
        .right  (right_col),
        .median (median)
    );

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_reg.load)
        begin
            c1_reg  <= s1_reg.col0 ? new_col : c2_reg;
            c2_reg  <= new_col;
            cw2_reg <= mid_rdata_reg;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pix_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_emit)
        begin
            out_pixel_reg <= (cw2_reg & ~LUMA_MASK) | (PIX_W'(median) << LUMA_LSB);
            frame_end_reg <= s1_reg.eor & s1_reg.fend;
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.out_pixel = out_pixel_reg;
    assign pix_out.frame_end = frame_end_reg;

    `include "median3x3_luma_vuya_core_assert.svh"

    `MED3X3_ASSERT_IMPLY(a_no_line_hazard, act && wr_en, col_reg != s1_reg.addr, "line store read and write hit the same column")
    `MED3X3_ASSERT_NEXT(a_tail_wraps, act && tail_end && !cfg_fire, row_reg == '0 && col_reg == '0, "cursor did not wrap after the frame tail")
    `MED3X3_ASSERT_IMPLY(a_row_bound, size_ok, row_reg <= h_plus1, "row cursor ran past the frame tail")

endmodule

FILE: verif/median3x3_luma_vuya_checker.sv
// Checker that predicts the 3x3 luma median filter and compares its output words.
module median3x3_luma_vuya_checker
    import med3x3_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = 2048,
    parameter int unsigned MAX_HEIGHT = 2048
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pix_valid,
    input  logic             pix_ready,
    input  logic [PIX_W-1:0] pix_word,
    input  logic             pix_drain,
    input  logic             res_valid,
    input  logic             res_ready,
    input  logic [PIX_W-1:0] res_pixel,
    input  logic             res_frame_end,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  cfg_reg_t         cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output int unsigned      outstanding,
    output int unsigned      mismatches
);

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_end;
    } filtered_t;

    logic [PIX_W-1:0] upper_line [MAX_WIDTH];
    logic [PIX_W-1:0] middle_line [MAX_WIDTH];
    luma_t            win [9];
    logic [PIX_W-1:0] centre [KERNEL_SIDE];
    int unsigned      col;
    int unsigned      row;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    filtered_t        filtered_q [$];

    function automatic void restart_window();
        foreach (win[k])
            win[k] = '0;
        foreach (centre[k])
            centre[k] = '0;
        col = 0;
        row = 0;
    endfunction

    // The window is indexed column * 3 + row, with the left column first.
    function automatic void shift_window();
        for (int r = 0; r < 3; r++)
        begin
            win[r]     = win[3 + r];
            win[3 + r] = win[6 + r];
        end
        centre[0] = centre[1];
        centre[1] = centre[2];
    endfunction

    function automatic luma_t window_median();
        int lower;
        int not_higher;
        for (int a = 0; a < 9; a++)
        begin
            lower      = 0;
            not_higher = 0;
            for (int b = 0; b < 9; b++)
            begin
                if (win[b] < win[a])
                    lower++;
                if (win[b] <= win[a])
                    not_higher++;
            end
            if (lower <= 4 && not_higher >= 5)
                return win[a];
        end
        return win[0];
    endfunction

    function automatic void push_filtered(logic fend);
        filtered_t f;
        f.pixel     = (centre[1] & ~LUMA_MASK) | (PIX_W'(window_median()) << LUMA_LSB);
        f.frame_end = fend;
        filtered_q.push_back(f);
    endfunction

    function automatic void filter_pixel(logic [PIX_W-1:0] pix, logic drn);
        int unsigned      w;
        int unsigned      h;
        int unsigned      i;
        int unsigned      j;
        logic [PIX_W-1:0] top_w;
        logic [PIX_W-1:0] mid_w;
        luma_t            ct;
        luma_t            cm;
        luma_t            cb;
        w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        h = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
        i = row;
        j = col;
        if (w < KERNEL_SIDE || h < KERNEL_SIDE || j >= w)
            return;
        if (i < h && drn)
            return;
        // A new line closes the previous one, whose right edge repeats its last column.
        if (j == 0 && i >= 2)
        begin
            shift_window();
            win[6]    = win[3];
            win[7]    = win[4];
            win[8]    = win[5];
            centre[2] = centre[1];
            push_filtered(i == h + 1);
        end
        if (i >= h + 1)
        begin
            col = 0;
            row = 0;
            return;
        end
        if (i >= 1)
        begin
            mid_w = middle_line[j];
            top_w = (i >= 2) ? upper_line[j] : mid_w;
            ct    = top_w[LUMA_LSB +: LUMA_W];
            cm    = mid_w[LUMA_LSB +: LUMA_W];
            cb    = (i < h) ? pix[LUMA_LSB +: LUMA_W] : mid_w[LUMA_LSB +: LUMA_W];
            if (j == 0)
            begin
                win[3]    = ct;
                win[4]    = cm;
                win[5]    = cb;
                win[6]    = ct;
                win[7]    = cm;
                win[8]    = cb;
                centre[1] = mid_w;
                centre[2] = mid_w;
            end
            else
            begin
                shift_window();
                win[6]    = ct;
                win[7]    = cm;
                win[8]    = cb;
                centre[2] = mid_w;
                push_filtered(1'b0);
            end
        end
        if (i < h)
        begin
            upper_line[j]  = middle_line[j];
            middle_line[j] = pix;
        end
        j++;
        if (j >= w)
        begin
            j = 0;
            i++;
        end
        col = j;
        row = i;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        filtered_t want;
        if (!rst_n)
        begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            restart_window();
            filtered_q.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (filtered_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: out_pixel %08h frame_end %0b arrived with none pending",
                             $time, res_pixel, res_frame_end);
                end
                else
                begin
                    want = filtered_q.pop_front();
                    if (res_pixel !== want.pixel)
                    begin
                        mismatches++;
                        $display("%0t: out_pixel expected %08h, actual %08h",
                                 $time, want.pixel, res_pixel);
                    end
                    if (res_frame_end !== want.frame_end)
                    begin
                        mismatches++;
                        $display("%0t: frame_end expected %0b, actual %0b",
                                 $time, want.frame_end, res_frame_end);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_FRAME_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
                restart_window();
            end
            if (pix_valid && pix_ready)
                filter_pixel(pix_word, pix_drain);
            outstanding <= filtered_q.size();
        end
    end

endmodule

FILE: verif/median3x3_luma_vuya_core_test.sv
// Testbench top for the 3x3 luma median filter: clock, reset, stimulus and verdict.
module median3x3_luma_vuya_core_test;
    import med3x3_pkg::*;

    localparam int unsigned MAX_WIDTH     = 2048;
    localparam int unsigned MAX_HEIGHT    = 2048;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned PHASE_WORDS   = 440;

    logic        clk;
    logic        rst_n;
    int unsigned cycle_count = 0;
    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    int unsigned frame_words;
    int unsigned outstanding;
    int unsigned mismatches;

    med3x3_pix_if pix_in();
    med3x3_out_if pix_out();
    med3x3_cfg_if cfg();

    median3x3_luma_vuya_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in),
        .pix_out (pix_out),
        .cfg     (cfg)
    );

    median3x3_luma_vuya_checker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .pix_valid     (pix_in.valid),
        .pix_ready     (pix_in.ready),
        .pix_word      (pix_in.pixel_word),
        .pix_drain     (pix_in.drain),
        .res_valid     (pix_out.valid),
        .res_ready     (pix_out.ready),
        .res_pixel     (pix_out.out_pixel),
        .res_frame_end (pix_out.frame_end),
        .cfg_valid     (cfg.valid),
        .cfg_ready     (cfg.ready),
        .cfg_index     (cfg.reg_index),
        .cfg_data      (cfg.wr_data),
        .outstanding   (outstanding),
        .mismatches    (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        pix_out.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            pix_out.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic send_word(input logic [PIX_W-1:0] word, input logic drn);
        while ($urandom_range(99) < src_idle_pct)
        begin
            pix_in.valid <= 1'b0;
            @(posedge clk);
        end
        pix_in.valid      <= 1'b1;
        pix_in.pixel_word <= word;
        pix_in.drain      <= drn;
        @(posedge clk);
        while (!pix_in.ready)
            @(posedge clk);
    endtask

    // Lets every pending result drain and the pipeline go quiet.
    task automatic settle();
        pix_in.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
        cfg.valid     <= 1'b1;
        cfg.reg_index <= idx;
        cfg.wr_data   <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
    endtask

    task automatic configure(input int unsigned w_reg, input int unsigned h_reg);
        settle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(w_reg));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(h_reg));
        cfg.valid <= 1'b0;
    endtask

    // A full frame is its pixels followed by width + 1 tail words; a cut frame stops early.
    task automatic run_frame(input int unsigned w_reg, input int unsigned h_reg, input bit full);
        int unsigned      w;
        int unsigned      h;
        int unsigned      n;
        bit               few_levels;
        logic [PIX_W-1:0] word;
        w = (w_reg > MAX_WIDTH) ? MAX_WIDTH : w_reg;
        h = (h_reg > MAX_HEIGHT) ? MAX_HEIGHT : h_reg;
        few_levels = ($urandom_range(9) < 3);
        if (w < KERNEL_SIDE || h < KERNEL_SIDE)
        begin
            repeat (8) send_word($urandom, 1'($urandom_range(1)));
            return;
        end
        n = full ? w * h : $urandom_range(w * h - 1, 1);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(99) < 4)
                send_word($urandom, 1'b1);
            word = $urandom;
            if (few_levels)
                word[LUMA_LSB +: LUMA_W] = LUMA_W'($urandom_range(3));
            send_word(word, 1'b0);
        end
        if (full)
            for (int k = 0; k <= w; k++)
                send_word($urandom, $urandom_range(99) < 85);
        frame_words += n + (full ? w + 1 : 0);
    endtask

    initial
    begin
        int unsigned w_reg;
        int unsigned h_reg;
        int unsigned frames;
        bit          broken;
        rst_n = 1'b0;
        pix_in.valid      <= 1'b0;
        pix_in.pixel_word <= '0;
        pix_in.drain      <= 1'b0;
        cfg.valid         <= 1'b0;
        cfg.reg_index     <= REG_FRAME_WIDTH;
        cfg.wr_data       <= '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        frame_words    = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        configure(3, 3);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'hAAAA_AAAA, 1'b0);
        send_word(32'h1357_9BDF, 1'b1);
        send_word(32'h5555_5555, 1'b0);
        send_word(32'h00FF_0000, 1'b0);
        send_word(32'hFF00_FFFF, 1'b0);
        send_word(32'h0180_7F01, 1'b0);
        send_word(32'h12FE_3456, 1'b0);
        send_word(32'h8001_0080, 1'b0);
        send_word(32'h0000_0000, 1'b1);
        send_word(32'hDEAD_BEEF, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'h0000_0000, 1'b1);
        configure(2, 3);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0000_0000, 1'b1);
        configure(3, 0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b1);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 55;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 55;
                end
                default:
                begin
                    src_idle_pct   = 25;
                    sink_stall_pct = 25;
                end
            endcase
            frame_words = 0;
            while (frame_words < PHASE_WORDS)
            begin
                case ($urandom_range(9))
                    0:
                    begin
                        w_reg = $urandom_range(2);
                        h_reg = $urandom_range(8, 3);
                    end
                    1:
                    begin
                        w_reg = $urandom_range(8, 3);
                        h_reg = $urandom_range(2);
                    end
                    2:
                    begin
                        w_reg = $urandom_range(64, 13);
                        h_reg = $urandom_range(5, 3);
                    end
                    default:
                    begin
                        w_reg = $urandom_range(12, 3);
                        h_reg = $urandom_range(8, 3);
                    end
                endcase
                configure(w_reg, h_reg);
                frames = $urandom_range(3, 1);
                broken = ($urandom_range(4) == 0);
                for (int k = 0; k < frames; k++)
                    run_frame(w_reg, h_reg, !(broken && k == frames - 1));
            end
        end

        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/med3x3_pkg.sv
hdl/med3x3_if.sv
hdl/med3x3_median9.sv
hdl/median3x3_luma_vuya_core.sv
verif/median3x3_luma_vuya_checker.sv
verif/median3x3_luma_vuya_core_test.sv
